### src/b32e_pkg.sv
// Shared types, constants and the symbol lookup for the base32 byte-stream encoder.
// No dependencies; every other file of the encoder imports this package.
`default_nettype none

package b32e_pkg;

    // Alphabet string; character i sits at bits [8*(31-i) +: 8].
    localparam logic [255:0] ALPHA_STR = "23456789abcdefghijkmnpqrstuvwxyz";
    localparam int unsigned  MAX_SYMS  = 3;
    localparam logic [2:0]   GROUP_W   = 3'd5;
    localparam logic [3:0]   BYTE_W    = 4'd8;
    localparam logic [3:0]   TWO_GROUP = 4'd10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [6:0] symbol_char;
        logic       last_symbol;
    } t_out;

    // Up to three symbols produced by one byte, slot 0 goes out first.
    typedef struct packed {
        logic [1:0]       num;
        t_out [MAX_SYMS-1:0] sym;
    } t_sym_grp;

    function automatic logic [6:0] sym_char(input logic [4:0] idx);
        logic [7:0] c;
        c = ALPHA_STR[{~idx, 3'b000} +: 8];
        return c[6:0];
    endfunction

endpackage

`default_nettype wire

### src/base32_byte_stream_encoder.sv
// Top level of the base32 byte-stream encoder (unpadded, custom alphabet).
// Depends on b32e_pkg, b32e_pack and b32e_outq.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall with i_in_data (one byte plus an
//   end-of-message flag). A byte is taken at a clock edge where i_in_valid is
//   high and o_in_stall is low.
//   Output channel: o_out_valid / i_out_stall with o_out_data (one ASCII
//   symbol plus a last-symbol mark). A symbol leaves at an edge where
//   o_out_valid is high and i_out_stall is low.
//   Each byte yields one to three symbols, all computed in the cycle it is
//   taken and held in a small result register; the first symbol is valid
//   in the cycle after the input transaction, then one symbol per cycle
//   follows while i_out_stall is low. A byte makes one or two symbols (three
//   on a final flush), sent out one at a time by the single output port.
//   The next byte is taken in the same cycle the last held symbol leaves.
//   Stall: while i_out_stall is high the held symbol stays put. o_in_stall is
//   high while more than one symbol is held, and also while the last held
//   symbol is stalled.
//   Reset (i_rst_n low, synchronous): carried bits and the symbol count of
//   the result register are cleared; the block starts a fresh message.
`default_nettype none

module base32_byte_stream_encoder (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  b32e_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output b32e_pkg::t_out    o_out_data
);
    import b32e_pkg::*;

    t_sym_grp grp;
    logic     load_ok;
    logic     accept;

    // Accept a byte whenever the result register can take its symbols.
    assign o_in_stall = !load_ok;
    assign accept     = i_in_valid && load_ok;

    // Split the byte into groups and advance the carried bits.
    b32e_pack u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_in_data),
        .o_grp    (grp)
    );

    // Hold the symbols and send them one per transaction.
    b32e_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept),
        .i_grp     (grp),
        .o_load_ok (load_ok),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_data    (o_out_data)
    );

endmodule

`default_nettype wire

### src/b32e_pack.sv
// Bit packer: holds the carried bits and splits each byte into 5-bit groups.
// Depends on b32e_pkg for the payload types and the alphabet lookup.
`default_nettype none

module b32e_pack (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_accept,
    input  b32e_pkg::t_in      i_data,
    output b32e_pkg::t_sym_grp o_grp
);
    import b32e_pkg::*;

    logic [3:0]  r_bits, n_bits;
    logic [2:0]  r_cnt,  n_cnt;

    logic [11:0] acc;
    logic [3:0]  total;
    logic        two;
    logic [2:0]  rem;
    logic [3:0]  sh0, sh1;
    logic [11:0] sh_a0, sh_a1;
    logic [4:0]  g0, g1;
    logic [4:0]  mask5;
    logic [3:0]  left;
    logic [4:0]  left5, flush;
    logic        fin, has_flush;

    always_comb begin
        fin   = i_data.end_of_message;
        acc   = {r_bits, i_data.data_byte};
        total = {1'b0, r_cnt} + BYTE_W;
        two   = (total >= TWO_GROUP);
        sh0   = total - {1'b0, GROUP_W};
        sh1   = total - TWO_GROUP;
        rem   = two ? sh1[2:0] : sh0[2:0];
        sh_a0 = acc >> sh0;
        sh_a1 = acc >> sh1;
        g0    = sh_a0[4:0];
        g1    = sh_a1[4:0];
        mask5 = (5'd1 << rem) - 5'd1;
        left  = acc[3:0] & mask5[3:0];
        left5 = {1'b0, left};
        flush = left5 << (GROUP_W - rem);
        has_flush = fin && (rem != 3'd0);

        o_grp.num = 2'd1 + {1'b0, two} + {1'b0, has_flush};
        o_grp.sym[0].symbol_char = sym_char(g0);
        o_grp.sym[0].last_symbol = fin && !two && (rem == 3'd0);
        o_grp.sym[1].symbol_char = sym_char(two ? g1 : flush);
        o_grp.sym[1].last_symbol = two ? (fin && (rem == 3'd0)) : 1'b1;
        o_grp.sym[2].symbol_char = sym_char(flush);
        o_grp.sym[2].last_symbol = 1'b1;

        // Drop the carry at message end, otherwise keep what is left over.
        n_bits = r_bits;
        n_cnt  = r_cnt;
        if (i_accept) begin
            n_bits = fin ? 4'd0 : left;
            n_cnt  = fin ? 3'd0 : rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= 4'd0;
            r_cnt  <= 3'd0;
        end else begin
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

### src/b32e_outq.sv
// Result register: holds one byte's symbols, sends one per cycle unless stalled.
// Depends on b32e_pkg for the payload types.
`default_nettype none

module b32e_outq (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_load,
    input  b32e_pkg::t_sym_grp i_grp,
    output logic               o_load_ok,
    output logic               o_valid,
    input  wire                i_stall,
    output b32e_pkg::t_out     o_data
);
    import b32e_pkg::*;

    logic [1:0]                r_num, n_num;
    t_out [MAX_SYMS-1:0]       r_sym, n_sym;
    logic                      take;

    always_comb begin
        o_valid   = (r_num != 2'd0);
        o_data    = r_sym[0];
        take      = o_valid && !i_stall;
        // Take a new byte once the held symbols are gone or the last one leaves now.
        o_load_ok = (r_num == 2'd0) || ((r_num == 2'd1) && !i_stall);

        n_num = r_num;
        n_sym = r_sym;
        if (i_load) begin
            n_num = i_grp.num;
            n_sym = i_grp.sym;
        end else if (take) begin
            n_num = r_num - 2'd1;
            n_sym = {r_sym[MAX_SYMS-1], r_sym[MAX_SYMS-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= 2'd0;
        end else begin
            r_num <= n_num;
        end
        r_sym <= n_sym;
    end

endmodule

`default_nettype wire
